// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// uer_pkg
// Types, register map and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uer_pkg;

   // Register map.
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 28;
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER_TICKS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOLDOFF_TICKS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ECHO_TIMEOUT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_INTERVAL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TEMPERATURE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_DISTANCE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DISTANCE = 3'd6;

   // Field widths.
   localparam int unsigned TRIG_W = 10;
   localparam int unsigned HOLD_W = 16;
   localparam int unsigned TICK_W = 20;
   localparam int unsigned EL_W = TICK_W + 1;
   localparam int unsigned TEMP_W = 16;
   localparam int unsigned DIST_W = 28;
   localparam int unsigned BASE_W = 17;
   localparam int unsigned COEF_W = 10;
   localparam int unsigned SPEED_W = 26;
   localparam int unsigned PROD_W = EL_W + SPEED_W;
   localparam int unsigned ROUND_SHIFT = 17;
   localparam int unsigned DRAW_W = PROD_W + 1 - ROUND_SHIFT;
   // Wide enough for any elapsed-since-echo counter width plus one zero bit.
   localparam int unsigned CMP_W = 33;

   // Reset values.
   localparam logic [TRIG_W-1:0] TRIGGER_RESET = 10'd10;
   localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 16'd750;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 20'd30000;
   localparam logic [TICK_W-1:0] INTERVAL_RESET = 20'd60000;
   localparam logic signed [TEMP_W-1:0] TEMP_RESET = 16'sd5120;
   localparam logic [DIST_W-1:0] MIN_DIST_RESET = 28'd20000;
   localparam logic [DIST_W-1:0] MAX_DIST_RESET = 28'd4000000;

   // Default model constants.
   localparam int unsigned SOUND_SPEED_BASE = 84813;
   localparam int unsigned SOUND_SPEED_COEF = 155;
   localparam int unsigned TICK_BITS = 20;

   typedef enum logic [1:0] {
      ST_CHECKED = 2'd0,
      ST_RANGE   = 2'd1,
      ST_FAILED  = 2'd2
   } status_type;

   // Per-transaction control bits carried down the pipeline.
   typedef struct packed {
      logic       trigger_out;
      logic       echo_is_input;
      logic       busy;
      logic       done;
      status_type status;
      logic       judge;
   } flags_type;

   // Speed of sound in Q16 m/s, clamped at zero.
   function automatic logic [SPEED_W-1:0] speed_calc(
      input logic [BASE_W-1:0] base,
      input logic [COEF_W-1:0] coef,
      input logic signed [TEMP_W-1:0] temp
   );
      logic signed [SPEED_W+1:0] sum;
      sum = $signed({3'b000, base, 8'h00}) + $signed({1'b0, coef}) * temp;
      if (sum < 0) begin
         return '0;
      end
      return sum[SPEED_W-1:0];
   endfunction

endpackage

// ===== rtl/ultrasonic_echo_ranger_core.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core
// Trigger/echo sequencer and distance calculator for an HC-SR04 style sensor.
// ----------------------------------------------------------------------------
// Each request transaction is one 1 us tick carrying the start request and the
// sampled echo level, and each tick yields exactly one response transaction.
// The block takes one tick per clock cycle unless a stalled response output has
// filled the pipeline: the sequencer state is updated at the moment a tick is
// accepted, and the response travels through a three register pipeline
// (sequencer result, speed multiplier, round and range check). The pipeline
// collapses bubbles, so ticks keep being accepted while a finished response
// waits to be taken, until the earlier stages are full. Register
// writes on the csr_ port complete in the cycle they are presented; a write to
// the temperature register recomputes the speed of sound in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ultrasonic_echo_ranger_core #(
   parameter int unsigned SoundSpeedBase = uer_pkg::SOUND_SPEED_BASE,
   parameter int unsigned SoundSpeedCoef = uer_pkg::SOUND_SPEED_COEF,
   parameter int unsigned TickBits = uer_pkg::TICK_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   // Tick input channel.
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_start_req,
   input  logic                             req_echo_level,
   // Response channel.
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_trigger_out,
   output logic                             rsp_echo_is_input,
   output logic                             rsp_busy_res,
   output logic                             rsp_done_res,
   output logic [1:0]                       rsp_status,
   output logic [uer_pkg::DIST_W-1:0]       rsp_distance,
   // Register write channel.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [uer_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [uer_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_TRIG   = 3'd1,
      PH_HOLD   = 3'd2,
      PH_WAITHI = 3'd3,
      PH_PULSE  = 3'd4
   } phase_type;

   localparam logic [uer_pkg::SPEED_W-1:0] SpeedReset = uer_pkg::speed_calc(
      uer_pkg::BASE_W'(SoundSpeedBase), uer_pkg::COEF_W'(SoundSpeedCoef),
      uer_pkg::TEMP_RESET);

   // Configuration registers. Temperature is kept only as the derived speed.
   logic [uer_pkg::TRIG_W-1:0]  trigger_ticks_ff;
   logic [uer_pkg::HOLD_W-1:0]  holdoff_ticks_ff;
   logic [uer_pkg::TICK_W-1:0]  echo_timeout_ff;
   logic [uer_pkg::TICK_W-1:0]  min_interval_ff;
   logic [uer_pkg::SPEED_W-1:0] speed_ff;
   logic [uer_pkg::DIST_W-1:0]  min_distance_ff;
   logic [uer_pkg::DIST_W-1:0]  max_distance_ff;

   // Sequencer state.
   phase_type                   phase_ff, phase_in;
   logic [uer_pkg::TICK_W-1:0]  phase_ticks_ff, phase_ticks_in;
   logic [TickBits-1:0]         since_echo_ff, since_echo_in;

   // Pipeline registers.
   logic                        s1_valid_ff, s2_valid_ff, out_valid_ff;
   uer_pkg::flags_type          s1_flags_ff, s1_flags_in;
   uer_pkg::flags_type          s2_flags_ff;
   logic [uer_pkg::EL_W-1:0]    s1_el_ff, s1_el_in;
   logic [uer_pkg::PROD_W-1:0]  s2_prod_ff, s2_prod_in;
   uer_pkg::flags_type          out_flags_ff, out_flags_in;
   logic [uer_pkg::DIST_W-1:0]  out_dist_ff, out_dist_in;

   logic                        req_fire;
   logic                        out_open, s2_open, s1_open;
   logic [uer_pkg::EL_W-1:0]    elapsed;
   logic                        start_refused;
   logic [uer_pkg::PROD_W:0]    rounded;
   logic [uer_pkg::DRAW_W-1:0]  dist_raw;
   logic                        out_of_range;

   // Bubble-collapsing handshake: a stage loads when it is empty or its
   // contents move on in the same cycle.
   assign out_open  = !out_valid_ff || rsp_ready;
   assign s2_open   = !s2_valid_ff || out_open;
   assign s1_open   = !s1_valid_ff || s2_open;
   assign req_ready = s1_open;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // A start is refused while too little time has passed since the last echo.
   assign elapsed = {1'b0, phase_ticks_ff} + uer_pkg::EL_W'(1);
   assign start_refused = uer_pkg::CMP_W'(since_echo_ff) < uer_pkg::CMP_W'(min_interval_ff);

   // Sequencer: next state and the control part of this tick's response.
   always_comb begin
      phase_in = phase_ff;
      phase_ticks_in = phase_ticks_ff;
      s1_flags_in = '0;
      s1_flags_in.status = uer_pkg::ST_CHECKED;
      s1_el_in = elapsed;
      case (phase_ff)
         PH_IDLE: begin
            if (req_start_req) begin
               if (start_refused) begin
                  s1_flags_in.done = 1'b1;
                  s1_flags_in.status = uer_pkg::ST_FAILED;
               end else begin
                  phase_in = PH_TRIG;
                  phase_ticks_in = uer_pkg::TICK_W'(1);
                  s1_flags_in.trigger_out = 1'b1;
               end
            end
         end
         PH_TRIG: begin
            if (phase_ticks_ff >= uer_pkg::TICK_W'(trigger_ticks_ff)) begin
               phase_in = PH_HOLD;
               phase_ticks_in = '0;
               s1_flags_in.echo_is_input = 1'b1;
            end else begin
               phase_ticks_in = elapsed[uer_pkg::TICK_W-1:0];
               s1_flags_in.trigger_out = 1'b1;
            end
         end
         PH_HOLD: begin
            s1_flags_in.echo_is_input = 1'b1;
            if (elapsed >= uer_pkg::EL_W'(holdoff_ticks_ff)) begin
               phase_in = PH_WAITHI;
               phase_ticks_in = '0;
            end else begin
               phase_ticks_in = elapsed[uer_pkg::TICK_W-1:0];
            end
         end
         PH_WAITHI: begin
            s1_flags_in.echo_is_input = 1'b1;
            if (req_echo_level) begin
               phase_in = PH_PULSE;
               phase_ticks_in = '0;
            end else if (elapsed > uer_pkg::EL_W'(echo_timeout_ff)) begin
               phase_in = PH_IDLE;
               phase_ticks_in = '0;
               s1_flags_in.done = 1'b1;
               s1_flags_in.status = uer_pkg::ST_FAILED;
            end else begin
               phase_ticks_in = elapsed[uer_pkg::TICK_W-1:0];
            end
         end
         PH_PULSE: begin
            s1_flags_in.echo_is_input = 1'b1;
            if (!req_echo_level) begin
               // Echo ended: the pulse length goes on to the distance stages.
               phase_in = PH_IDLE;
               phase_ticks_in = '0;
               s1_flags_in.done = 1'b1;
               s1_flags_in.judge = 1'b1;
            end else if (elapsed > uer_pkg::EL_W'(echo_timeout_ff)) begin
               phase_in = PH_IDLE;
               phase_ticks_in = '0;
               s1_flags_in.done = 1'b1;
               s1_flags_in.status = uer_pkg::ST_FAILED;
            end else begin
               phase_ticks_in = elapsed[uer_pkg::TICK_W-1:0];
            end
         end
         default: begin
            phase_in = PH_IDLE;
            phase_ticks_in = '0;
         end
      endcase
      s1_flags_in.busy = (phase_in != PH_IDLE);

      // Time since the end of the last completed echo, saturating.
      if (s1_flags_in.judge) begin
         since_echo_in = '0;
      end else if (since_echo_ff != '1) begin
         since_echo_in = since_echo_ff + TickBits'(1);
      end else begin
         since_echo_in = since_echo_ff;
      end
   end

   // Multiplier stage: pulse ticks times speed in Q16 m/s.
   assign s2_prod_in = uer_pkg::PROD_W'(s1_el_ff) * uer_pkg::PROD_W'(speed_ff);

   // Final stage: drop the Q16 fraction and halve with round to nearest, then check the limits.
   assign rounded  = (uer_pkg::PROD_W+1)'(s2_prod_ff) +
                     (uer_pkg::PROD_W+1)'(1 << (uer_pkg::ROUND_SHIFT - 1));
   assign dist_raw = rounded[uer_pkg::PROD_W:uer_pkg::ROUND_SHIFT];
   assign out_of_range = (dist_raw[uer_pkg::DRAW_W-1:uer_pkg::DIST_W] != '0) ||
                         (dist_raw[uer_pkg::DIST_W-1:0] < min_distance_ff) ||
                         (dist_raw[uer_pkg::DIST_W-1:0] > max_distance_ff);

   always_comb begin
      out_flags_in = s2_flags_ff;
      out_dist_in = '0;
      if (s2_flags_ff.judge) begin
         if (out_of_range) begin
            out_flags_in.status = uer_pkg::ST_RANGE;
         end else begin
            out_flags_in.status = uer_pkg::ST_CHECKED;
            out_dist_in = dist_raw[uer_pkg::DIST_W-1:0];
         end
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ticks_ff <= uer_pkg::TRIGGER_RESET;
         holdoff_ticks_ff <= uer_pkg::HOLDOFF_RESET;
         echo_timeout_ff  <= uer_pkg::TIMEOUT_RESET;
         min_interval_ff  <= uer_pkg::INTERVAL_RESET;
         speed_ff         <= SpeedReset;
         min_distance_ff  <= uer_pkg::MIN_DIST_RESET;
         max_distance_ff  <= uer_pkg::MAX_DIST_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            uer_pkg::REG_TRIGGER_TICKS: trigger_ticks_ff <= csr_wdata[uer_pkg::TRIG_W-1:0];
            uer_pkg::REG_HOLDOFF_TICKS: holdoff_ticks_ff <= csr_wdata[uer_pkg::HOLD_W-1:0];
            uer_pkg::REG_ECHO_TIMEOUT:  echo_timeout_ff  <= csr_wdata[uer_pkg::TICK_W-1:0];
            uer_pkg::REG_MIN_INTERVAL:  min_interval_ff  <= csr_wdata[uer_pkg::TICK_W-1:0];
            uer_pkg::REG_TEMPERATURE: begin
               speed_ff <= uer_pkg::speed_calc(uer_pkg::BASE_W'(SoundSpeedBase),
                                               uer_pkg::COEF_W'(SoundSpeedCoef),
                                               $signed(csr_wdata[uer_pkg::TEMP_W-1:0]));
            end
            uer_pkg::REG_MIN_DISTANCE:  min_distance_ff  <= csr_wdata[uer_pkg::DIST_W-1:0];
            uer_pkg::REG_MAX_DISTANCE:  max_distance_ff  <= csr_wdata[uer_pkg::DIST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer state advances once per accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         phase_ticks_ff <= '0;
         since_echo_ff  <= '1;
      end else if (req_fire) begin
         phase_ff       <= phase_in;
         phase_ticks_ff <= phase_ticks_in;
         since_echo_ff  <= since_echo_in;
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_open) begin
            s1_valid_ff <= req_fire;
         end
         if (s2_open) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_open) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_flags_ff <= s1_flags_in;
         s1_el_ff    <= s1_el_in;
      end
      if (s2_open && s1_valid_ff) begin
         s2_flags_ff <= s1_flags_ff;
         s2_prod_ff  <= s2_prod_in;
      end
      if (out_open && s2_valid_ff) begin
         out_flags_ff <= out_flags_in;
         out_dist_ff  <= out_dist_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_trigger_out   = out_flags_ff.trigger_out;
   assign rsp_echo_is_input = out_flags_ff.echo_is_input;
   assign rsp_busy_res      = out_flags_ff.busy;
   assign rsp_done_res      = out_flags_ff.done;
   assign rsp_status        = out_flags_ff.status;
   assign rsp_distance      = out_dist_ff;

   // The newest accepted tick sits in the first stage, so its busy bit must
   // agree with the sequencer phase it left behind.
   `ASSERT_IMPLY(a_busy_matches_phase, clock, reset, s1_valid_ff,
                 s1_flags_ff.busy == (phase_ff != PH_IDLE),
                 "busy flag disagrees with sequencer phase")

   // A nonzero distance only comes with a finished, checked reading.
   `ASSERT_IMPLY(a_dist_only_checked, clock, reset, rsp_valid && (rsp_distance != '0),
                 rsp_done_res && (rsp_status == uer_pkg::ST_CHECKED),
                 "distance reported without a checked reading")

   // Trigger and echo input are never active on the same tick.
   `ASSERT_IMPLY(a_trig_echo_exclusive, clock, reset, rsp_valid,
                 !(rsp_trigger_out && rsp_echo_is_input),
                 "trigger driven while echo pin is an input")

   // A refused start finishes at once without starting a reading.
   `ASSERT_NEXT(a_refused_start, clock, reset,
                req_fire && (phase_ff == PH_IDLE) && req_start_req && start_refused,
                s1_flags_ff.done && !s1_flags_ff.busy &&
                (s1_flags_ff.status == uer_pkg::ST_FAILED),
                "refused start did not report failure")

endmodule
